// File: rtl/memory_pattern_checker_defines.svh
// ----------------------------------------------------------------------------
// Memory pattern checker assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MEMORY_PATTERN_CHECKER_DEFINES_SVH
`define MEMORY_PATTERN_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// Memory pattern checker package
// Shared widths, register indexes, reset values and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_MAX_WORDS  = 65536;

  localparam int FIELD_W   = 32;
  localparam int INDEX_W   = 16;
  localparam int COUNT_W   = 17;
  localparam int RETRY_W   = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = COUNT_W;

  localparam logic [CFG_ADDR_W-1:0] REG_WORD_COUNT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_LIMIT = 1'b1;

  localparam logic [COUNT_W-1:0] WORD_COUNT_RST  = 17'd16384;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd10;

  typedef struct packed {
    logic [COUNT_W-1:0] word_count;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] word_index;
    logic [FIELD_W-1:0] expected_old;
    logic [FIELD_W-1:0] write_value;
    logic               delayed_error;
    logic               immediate_error;
    logic [FIELD_W-1:0] error_total;
    logic               pass_end;
    logic               halted;
  } result_t;

  typedef struct packed {
    logic               halt;
    logic [INDEX_W-1:0] index;
    logic [FIELD_W-1:0] error_total;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/mpc_core.sv
// ----------------------------------------------------------------------------
// Memory pattern checker core
// Holds the sweep state and checks one word per enabled cycle until it halts.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_core import mpc_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [FIELD_W-1:0] delayed_read_i,
  input  wire logic [FIELD_W-1:0] immediate_read_i,
  input  wire cfg_t               cfg_i,
  output result_t                 result_o,
  output status_t                 status_o
);

  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_WORDS);

  logic [DATA_WIDTH-1:0] pattern_q, pattern_d;
  logic [INDEX_W-1:0]    index_q, index_d;
  logic [FIELD_W-1:0]    error_q, error_d;
  logic [RETRY_W-1:0]    fail_q, fail_d;
  logic                  halt_q, halt_d;

  logic [DATA_WIDTH-1:0] old_pat, dr_w, ir_w;
  logic [63:0]           dr_ext, ir_ext, pat_ext, old_ext;
  logic                  derr, ierr, last_word, halt_now;
  logic [FIELD_W:0]      err_sum;
  logic [FIELD_W-1:0]    err_new;
  logic [RETRY_W-1:0]    fail_new;
  logic [COUNT_W-1:0]    eff_count, idx_inc;

  always_comb begin
    old_pat = ~pattern_q;

    // Only the low DATA_WIDTH bits take part in the compares.
    dr_ext = {32'b0, delayed_read_i};
    ir_ext = {32'b0, immediate_read_i};
    dr_w   = dr_ext[DATA_WIDTH-1:0];
    ir_w   = ir_ext[DATA_WIDTH-1:0];

    pat_ext = '0;
    pat_ext[DATA_WIDTH-1:0] = pattern_q;
    old_ext = '0;
    old_ext[DATA_WIDTH-1:0] = old_pat;

    derr = (dr_w != old_pat);
    ierr = (ir_w != pattern_q);

    err_sum = {1'b0, error_q} + {{FIELD_W{1'b0}}, derr} + {{FIELD_W{1'b0}}, ierr};
    err_new = err_sum[FIELD_W] ? {FIELD_W{1'b1}} : err_sum[FIELD_W-1:0];

    if (!ierr) begin
      fail_new = '0;
    end else if (fail_q == {RETRY_W{1'b1}}) begin
      fail_new = fail_q;
    end else begin
      fail_new = fail_q + RETRY_W'(1);
    end
    halt_now = (fail_new > cfg_i.retry_limit);

    // A zero count acts as one, a count above the depth as the depth.
    if (cfg_i.word_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (cfg_i.word_count > MaxCnt) begin
      eff_count = MaxCnt;
    end else begin
      eff_count = cfg_i.word_count;
    end
    idx_inc   = {1'b0, index_q} + COUNT_W'(1);
    last_word = (idx_inc >= eff_count);

    pattern_d = pattern_q;
    index_d   = index_q;
    error_d   = error_q;
    fail_d    = fail_q;
    halt_d    = halt_q;

    result_o.word_index      = index_q;
    result_o.expected_old    = old_ext[FIELD_W-1:0];
    result_o.write_value     = pat_ext[FIELD_W-1:0];
    result_o.delayed_error   = 1'b0;
    result_o.immediate_error = 1'b0;
    result_o.error_total     = error_q;
    result_o.pass_end        = 1'b0;
    result_o.halted          = halt_q;

    if (!halt_q) begin
      result_o.delayed_error   = derr;
      result_o.immediate_error = ierr;
      result_o.error_total     = err_new;
      result_o.halted          = halt_now;
      result_o.pass_end        = !halt_now && last_word;
      if (step_i) begin
        error_d = err_new;
        fail_d  = fail_new;
        if (halt_now) begin
          halt_d = 1'b1;
        end else if (last_word) begin
          index_d   = '0;
          pattern_d = old_pat;
        end else begin
          index_d = idx_inc[INDEX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '1;
      index_q   <= '0;
      error_q   <= '0;
      fail_q    <= '0;
      halt_q    <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      index_q   <= index_d;
      error_q   <= error_d;
      fail_q    <= fail_d;
      halt_q    <= halt_d;
    end
  end

  assign status_o.halt        = halt_q;
  assign status_o.index       = index_q;
  assign status_o.error_total = error_q;

endmodule

`default_nettype wire

// File: rtl/memory_pattern_checker.sv
// Flow: a beat accepted on the slave side is held in the input register, then
// checked into the result register and offered on the master side; one
// result per beat.
// Throughput: one beat per cycle when the master side gives no backpressure;
// both registers stall only on backpressure.
// Reset: asynchronous, active low; clears the pattern to all ones, the index,
// error total, failure run and halt flag, and restores both config registers.
// ----------------------------------------------------------------------------
// Memory pattern checker
// Checks a solid-pattern / inversion memory sweep one word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "memory_pattern_checker_defines.svh"

module memory_pattern_checker import mpc_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Slave side: one word of the test region per beat.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: delayed_read [31:0], immediate_read [63:32]
  input  wire logic [63:0]           s_axis_tdata,
  // Master side: one check result per beat.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: word_index [15:0], expected_old [47:16], write_value [79:48],
  // delayed_error [80], immediate_error [81], error_total [113:82],
  // halted [114], zero fill [119:115]
  output logic [119:0]               m_axis_tdata,
  // tlast: pass_end, set on the last word of a pass.
  output logic                       m_axis_tlast,
  // Configuration writes: index 0 is word_count, index 1 is retry_limit.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_WORDS);

  // Configuration registers.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WORD_COUNT:  cfg_d.word_count  = cfg_wdata_i;
        REG_RETRY_LIMIT: cfg_d.retry_limit = cfg_wdata_i[RETRY_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.word_count  <= WORD_COUNT_RST;
      cfg_q.retry_limit <= RETRY_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register. It takes a new beat whenever it is empty or is being
  // handed to the check stage in the same cycle.
  logic        in_valid_q, in_valid_d;
  logic [63:0] in_data_q;
  logic        advance;

  // Result register. The check stage fires when the result register is free
  // or is being drained, so the core is stepped exactly once per beat.
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;
  status_t status;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // The check core holds the sweep state and updates it on each advance until halted.
  mpc_core #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_WORDS  (MAX_WORDS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .delayed_read_i   (in_data_q[31:0]),
    .immediate_read_i (in_data_q[63:32]),
    .cfg_i            (cfg_q),
    .result_o         (res),
    .status_o         (status)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.pass_end;
  assign m_axis_tdata  = {5'b0, out_q.halted, out_q.error_total, out_q.immediate_error,
                          out_q.delayed_error, out_q.write_value, out_q.expected_old,
                          out_q.word_index};

  // Once halted, only reset brings the block back.
  `MPC_ASSERT_NEXT(a_halt_sticky, status.halt, status.halt, "halt flag cleared without reset")

  // The error total saturates and never goes down.
  `MPC_ASSERT_NEXT(a_total_monotonic, 1'b1, status.error_total >= $past(status.error_total),
    "error total decreased")

  // A halting word never ends a pass.
  `MPC_ASSERT_NOW(a_no_end_on_halt, out_valid_q && out_q.pass_end, !out_q.halted,
    "pass end reported together with halt")

  // The word index stays below the memory depth MAX_WORDS.
  `MPC_ASSERT_NOW(a_index_range, 1'b1, ({1'b0, status.index} < MaxCnt),
    "word index beyond memory depth")

endmodule

`default_nettype wire
